// ----- sv/uarb_pkg.sv -----
// Shared types, codes and sizes for the UART ring buffer engine.
// No dependencies; imported by uarb_ctrl and the top level.
package uarb_pkg;

   localparam int RX_DEPTH = 2048;
   localparam int TX_DEPTH = 8192;
   localparam int RX_AW    = $clog2(RX_DEPTH);
   localparam int TX_AW    = $clog2(TX_DEPTH);
   localparam int COUNT_W  = 11;

   localparam logic [7:0] LINE_ERR_MASK = 8'h1E;

   localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
   localparam logic [1:0] CMD_RX_READ  = 2'd1;
   localparam logic [1:0] CMD_TX_WRITE = 2'd2;
   localparam logic [1:0] CMD_TX_READY = 2'd3;

   localparam logic [1:0] REASON_NONE  = 2'd0;
   localparam logic [1:0] REASON_LINE  = 2'd1;
   localparam logic [1:0] REASON_FULL  = 2'd2;
   localparam logic [1:0] REASON_EMPTY = 2'd3;

   // Result of one request, minus the byte that comes back from a ring memory.
   typedef struct packed {
      logic               accepted;
      logic [1:0]         drop_reason;
      logic               out_valid;
      logic               sel_tx;
      logic [COUNT_W-1:0] rx_count;
      logic               tx_irq_enable;
   } uarb_meta_type;

endpackage

// ----- sv/uarb_ram.sv -----
// Generic single-clock byte memory, one write and one registered read port.
// No dependencies.
module uarb_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/uarb_ctrl.sv -----
// Ring pointers, batch-truncation flag and both ring memories.
// Depends on uarb_pkg and uarb_ram.
module uarb_ctrl
   import uarb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  logic [1:0]    command,
   input  logic [7:0]    line_status,
   input  logic [7:0]    data_byte,
   input  logic          write_last,
   output uarb_meta_type meta,
   output logic [7:0]    rx_rd_data,
   output logic [7:0]    tx_rd_data
);

   logic [RX_AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic             batch_ff, batch_in;
   logic             rx_wr, rx_rd, tx_wr, tx_rd;
   logic [RX_AW-1:0] rx_nxt;
   logic [TX_AW-1:0] tx_nxt;

   assign rx_nxt = rx_head_ff + 1'b1;
   assign tx_nxt = tx_head_ff + 1'b1;

   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      batch_in   = batch_ff;
      rx_wr      = 1'b0;
      rx_rd      = 1'b0;
      tx_wr      = 1'b0;
      tx_rd      = 1'b0;
      meta       = '0;
      case (command)
         CMD_RX_BYTE: begin
            if ((line_status & LINE_ERR_MASK) != 8'd0) begin
               meta.drop_reason = REASON_LINE;
            end else if (rx_nxt == rx_tail_ff) begin
               meta.drop_reason = REASON_FULL;
            end else begin
               rx_wr         = 1'b1;
               rx_head_in    = rx_nxt;
               meta.accepted = 1'b1;
            end
         end
         CMD_RX_READ: begin
            if (rx_head_ff == rx_tail_ff) begin
               meta.drop_reason = REASON_EMPTY;
            end else begin
               rx_rd          = 1'b1;
               rx_tail_in     = rx_tail_ff + 1'b1;
               meta.accepted  = 1'b1;
               meta.out_valid = 1'b1;
            end
         end
         CMD_TX_WRITE: begin
            // once a batch overflows, drop the rest of it up to its last byte
            if (batch_ff) begin
               meta.drop_reason = REASON_FULL;
            end else if (tx_nxt == tx_tail_ff) begin
               meta.drop_reason = REASON_FULL;
               batch_in         = 1'b1;
            end else begin
               tx_wr         = 1'b1;
               tx_head_in    = tx_nxt;
               meta.accepted = 1'b1;
            end
            if (write_last) begin
               batch_in = 1'b0;
            end
         end
         default: begin
            if (tx_head_ff == tx_tail_ff) begin
               meta.drop_reason = REASON_EMPTY;
            end else begin
               tx_rd          = 1'b1;
               tx_tail_in     = tx_tail_ff + 1'b1;
               meta.accepted  = 1'b1;
               meta.out_valid = 1'b1;
               meta.sel_tx    = 1'b1;
            end
         end
      endcase
      meta.rx_count      = COUNT_W'(rx_head_in - rx_tail_in);
      meta.tx_irq_enable = (tx_head_in != tx_tail_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         batch_ff   <= 1'b0;
      end else if (fire) begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         batch_ff   <= batch_in;
      end
   end

   uarb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
      .clock   (clock),
      .wr_en   (fire && rx_wr),
      .wr_addr (rx_head_ff),
      .wr_data (data_byte),
      .rd_en   (fire && rx_rd),
      .rd_addr (rx_tail_ff),
      .rd_data (rx_rd_data)
   );

   uarb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
      .clock   (clock),
      .wr_en   (fire && tx_wr),
      .wr_addr (tx_head_ff),
      .wr_data (data_byte),
      .rd_en   (fire && tx_rd),
      .rd_addr (tx_tail_ff),
      .rd_data (tx_rd_data)
   );

endmodule

// ----- sv/uart_ring_buffer_engine.sv -----
// Top level of the UART ring buffer engine: request/response handshake and pipeline.
// Depends on uarb_pkg and uarb_ctrl (which holds the ring memories).
//
//  channel | dir | tdata                               | tuser          | tlast
//  req_    | in  | line_status, data_byte              | command        | write_last
//  rsp_    | out | accepted, drop_reason, out_byte,    | out_valid      | -
//          |     | rx_count, tx_irq_enable             |                |
//
// One request per cycle sustained while rsp_tready stays high; a taken request
// passes through stage one (the memory read), then the response register.
// Pointers update when the request is taken, so the next request sees them.
// Synchronous active-high reset clears the pointers and the truncation flag;
// ring contents are not cleared.
// A stalled response holds the pipeline; req_tready drops only when both
// stages are full and rsp_tready is low.
module uart_ring_buffer_engine
   import uarb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] line_status, [15:8] data_byte
   input  logic [1:0]  req_tuser,  // [1:0] command
   input  logic        req_tlast,  // write_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [0] accepted, [2:1] drop_reason, [10:3] out_byte,
                                   // [21:11] rx_count, [22] tx_irq_enable, [23] zero
   output logic        rsp_tuser   // out_valid
);

   uarb_meta_type meta_in, s1_meta_ff, rsp_meta_ff;
   logic          s1_valid_ff, rsp_valid_ff;
   logic          req_fire, s1_adv;
   logic [7:0]    rx_rd_data, tx_rd_data, s1_byte;
   logic [7:0]    rsp_byte_ff;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   uarb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .command     (req_tuser),
      .line_status (req_tdata[7:0]),
      .data_byte   (req_tdata[15:8]),
      .write_last  (req_tlast),
      .meta        (meta_in),
      .rx_rd_data  (rx_rd_data),
      .tx_rd_data  (tx_rd_data)
   );

   // memory read data is valid while the request sits in stage one
   always_comb begin
      if (!s1_meta_ff.out_valid) begin
         s1_byte = 8'd0;
      end else if (s1_meta_ff.sel_tx) begin
         s1_byte = tx_rd_data;
      end else begin
         s1_byte = rx_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_meta_ff <= meta_in;
      end
      if (s1_adv) begin
         rsp_meta_ff <= s1_meta_ff;
         rsp_byte_ff <= s1_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_meta_ff.out_valid;
   assign rsp_tdata  = {1'b0, rsp_meta_ff.tx_irq_enable, rsp_meta_ff.rx_count,
                        rsp_byte_ff, rsp_meta_ff.drop_reason, rsp_meta_ff.accepted};

   a_byte_needs_accept : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_meta_ff.out_valid |-> rsp_meta_ff.accepted)
      else $error("response byte without accept");

   a_accept_no_reason : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_meta_ff.accepted |-> rsp_meta_ff.drop_reason == REASON_NONE)
      else $error("accepted response carries a drop reason");

   a_stall_blocks_req : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline is full");

   a_empty_byte_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_meta_ff.out_valid |-> rsp_byte_ff == 8'd0)
      else $error("byte not zero without out_valid");

endmodule
